// ===== sv/ssc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

  localparam logic [1:0] FUNC_WR_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_WR_COLOR  = 2'd1;
  localparam logic [1:0] FUNC_RENDER    = 2'd2;

  localparam logic [2:0] REG_SLICE_SIZE   = 3'd0;
  localparam logic [2:0] REG_PLOT_SIZE    = 3'd1;
  localparam logic [2:0] REG_VALUE_MIN    = 3'd2;
  localparam logic [2:0] REG_VALUE_MAX    = 3'd3;
  localparam logic [2:0] REG_CROP_COLUMNS = 3'd4;
  localparam logic [2:0] REG_CROP_ROWS    = 3'd5;
  localparam logic [2:0] REG_VIEW_MODE    = 3'd6;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        address;
    logic signed [15:0] sample;
    logic [23:0]        color_in;
    logic [15:0]        pixel_x;
    logic [15:0]        pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [23:0] color_out;
    logic        was_cropped;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/ssc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== sv/ssc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees num < den << QW, so the quotient fits in QW bits.
module ssc_div #(
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [DW+QW-1:0]   num,
  input  logic [DW-1:0]      den,
  input  logic [SW-1:0]      side_in,
  output logic               out_valid,
  output logic [QW-1:0]      quo,
  output logic [SW-1:0]      side_out
);

  logic          valid_q [QW];
  logic [DW-1:0] rem_q   [QW];
  logic [QW-1:0] low_q   [QW];
  logic [QW-1:0] quo_q   [QW];
  logic [DW-1:0] den_q   [QW];
  logic [SW-1:0] side_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_i;
    logic [DW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [QW-1:0] low_i;
    logic [QW-1:0] quo_i;
    logic [SW-1:0] side_i;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = num[DW+QW-1:QW];
      assign low_i  = num[QW-1:0];
      assign quo_i  = '0;
      assign den_i  = den;
      assign side_i = side_in;
    end else begin : g_next
      assign v_i    = valid_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign low_i  = low_q[k-1];
      assign quo_i  = quo_q[k-1];
      assign den_i  = den_q[k-1];
      assign side_i = side_q[k-1];
    end

    assign trial = {rem_i, low_i[QW-1]};
    assign take  = (trial >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[k]  <= take ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
      low_q[k]  <= low_i << 1;
      quo_q[k]  <= (quo_i << 1) | QW'(take);
      den_q[k]  <= den_i;
      side_q[k] <= side_i;
    end
  end

  assign out_valid = valid_q[QW-1];
  assign quo       = quo_q[QW-1];
  assign side_out  = side_q[QW-1];

endmodule

`default_nettype wire

// ===== sv/scaled_slice_colormap_render_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one item per cycle; busy stays low, so a transfer is taken every cycle.
// The pipeline holds bit-per-stage dividers (16 stages each for x and y scaling, and
// log2(TABLE_SIZE) for the color index) and registered slice and color memory reads.
// Synchronous reset clears the pipeline valids and loads the register defaults;
// both memories hold no defined contents until written. Results cannot be stalled.
module scaled_slice_colormap_render_core import ssc_pkg::*; #(
  parameter int SLICE_WORDS = 65536,
  parameter int TABLE_SIZE  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  item,
  output logic      busy,
  output logic      done,
  output out_item_t result,
  input  logic      cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Both depths are taken as powers of two.
  localparam int AW = $clog2(SLICE_WORDS);
  localparam int QW = $clog2(TABLE_SIZE);
  localparam int SB = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int IW = $bits(in_item_t);
  localparam logic [QW-1:0] TMAX = QW'(TABLE_SIZE - 1);

  logic [31:0]        slice_size;
  logic [31:0]        plot_size;
  logic signed [15:0] value_min;
  logic signed [15:0] value_max;
  logic [31:0]        crop_columns;
  logic [31:0]        crop_rows;
  logic [1:0]         view_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_size   <= 32'h0001_0001;
      plot_size    <= 32'h0001_0001;
      value_min    <= -16'sd32768;
      value_max    <= 16'sd32767;
      crop_columns <= 32'hFFFF_0000;
      crop_rows    <= 32'hFFFF_0000;
      view_mode    <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLICE_SIZE:   slice_size   <= cfg_data;
        REG_PLOT_SIZE:    plot_size    <= cfg_data;
        REG_VALUE_MIN:    value_min    <= cfg_data[15:0];
        REG_VALUE_MAX:    value_max    <= cfg_data[15:0];
        REG_CROP_COLUMNS: crop_columns <= cfg_data;
        REG_CROP_ROWS:    crop_rows    <= cfg_data;
        REG_VIEW_MODE:    view_mode    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        cols, rows, pw, ph;
  logic signed [16:0] lo, hi;
  logic [15:0]        span;

  assign cols = (slice_size[15:0] == 16'd0) ? 16'd1 : slice_size[15:0];
  assign rows = (slice_size[31:16] == 16'd0) ? 16'd1 : slice_size[31:16];
  assign pw   = (plot_size[15:0] == 16'd0) ? 16'd1 : plot_size[15:0];
  assign ph   = (plot_size[31:16] == 16'd0) ? 16'd1 : plot_size[31:16];
  assign lo   = 17'(value_min);
  // An empty window becomes [min, min+1].
  assign hi   = (value_max > value_min) ? 17'(value_max) : lo + 17'sd1;
  assign span = 16'(hi - lo);

  assign busy = 1'b0;

  // Stage 0: input register.
  logic     v0;
  in_item_t it0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= start;
  end
  always_ff @(posedge clk) begin
    it0 <= item;
  end

  // Stage 1: scaling products. A pixel at or past the plot edge saturates.
  logic        v1;
  in_item_t    it1;
  logic [31:0] nx1, ny1;
  logic        fx1, fy1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= v0;
  end
  always_ff @(posedge clk) begin
    it1 <= it0;
    nx1 <= it0.pixel_x * cols;
    ny1 <= it0.pixel_y * rows;
    fx1 <= (it0.pixel_x >= pw);
    fy1 <= (it0.pixel_y >= ph);
  end

  logic          vdx, vdy;
  logic [15:0]   qx, qy;
  logic [IW:0]   sidex;
  logic          fyd;

  ssc_div #(.DW(16), .QW(16), .SW(IW + 1)) u_div_x (
    .clk(clk), .rst(rst), .in_valid(v1), .num(nx1), .den(pw),
    .side_in({fx1, it1}), .out_valid(vdx), .quo(qx), .side_out(sidex)
  );

  ssc_div #(.DW(16), .QW(16), .SW(1)) u_div_y (
    .clk(clk), .rst(rst), .in_valid(v1), .num(ny1), .den(ph),
    .side_in(fy1), .out_valid(vdy), .quo(qy), .side_out(fyd)
  );

  // Stage 2: saturate and flip.
  logic        v2;
  in_item_t    it2;
  logic [15:0] sx2, sy2, sy_raw;
  assign sy_raw = fyd ? rows - 16'd1 : qy;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= vdx & vdy;
  end
  always_ff @(posedge clk) begin
    it2 <= sidex[IW-1:0];
    sx2 <= sidex[IW] ? cols - 16'd1 : qx;
    sy2 <= view_mode[0] ? rows - 16'd1 - sy_raw : sy_raw;
  end

  // Stage 3: crop test and row offset.
  logic        v3;
  in_item_t    it3;
  logic [15:0] sx3;
  logic [31:0] prod3;
  logic        crop3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end
  always_ff @(posedge clk) begin
    it3   <= it2;
    sx3   <= sx2;
    prod3 <= sy2 * cols;
    crop3 <= view_mode[1]
          || (sx2 < crop_columns[15:0]) || (sx2 > crop_columns[31:16])
          || (sy2 < crop_rows[15:0])    || (sy2 > crop_rows[31:16]);
  end

  // Slice writes travel down to this stage so reads and writes keep item order.
  logic [31:0]   sum3;
  logic [AW-1:0] slice_addr;
  logic          slice_we;
  logic [SB-1:0] slice_rdata;
  assign sum3       = prod3 + 32'(sx3);
  assign slice_we   = v3 && (it3.func == FUNC_WR_SAMPLE);
  assign slice_addr = (it3.func == FUNC_RENDER) ? sum3[AW-1:0]
                                                : AW'({16'd0, it3.address});

  ssc_ram #(.WIDTH(SB), .DEPTH(SLICE_WORDS)) u_slice_ram (
    .clk(clk), .we(slice_we), .addr(slice_addr),
    .wdata(it3.sample[SB-1:0]), .rdata(slice_rdata)
  );

  // Stage 4: sample read.
  logic     v4;
  in_item_t it4;
  logic     crop4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
  end
  always_ff @(posedge clk) begin
    it4   <= it3;
    crop4 <= crop3;
  end

  // Stage 5: window clamp.
  logic signed [16:0] vs, vc;
  assign vs = 17'(signed'(slice_rdata));
  assign vc = (vs < lo) ? lo : ((vs > hi) ? hi : vs);

  logic        v5;
  in_item_t    it5;
  logic        crop5;
  logic [15:0] d5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
  end
  always_ff @(posedge clk) begin
    it5   <= it4;
    crop5 <= crop4;
    d5    <= 16'(vc - lo);
  end

  // Stage 6: scale to the table range.
  logic           v6;
  in_item_t       it6;
  logic           crop6;
  logic [15+QW:0] n6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
  end
  always_ff @(posedge clk) begin
    it6   <= it5;
    crop6 <= crop5;
    n6    <= (16 + QW)'(d5) * (16 + QW)'(TMAX);
  end

  logic          vdi;
  logic [QW-1:0] qi;
  logic [IW:0]   sidei;
  in_item_t      itd;

  ssc_div #(.DW(16), .QW(QW), .SW(IW + 1)) u_div_idx (
    .clk(clk), .rst(rst), .in_valid(v6), .num(n6), .den(span),
    .side_in({crop6, it6}), .out_valid(vdi), .quo(qi), .side_out(sidei)
  );

  assign itd = sidei[IW-1:0];

  logic          color_we;
  logic [QW-1:0] color_addr;
  logic [23:0]   color_rdata;
  assign color_we   = vdi && (itd.func == FUNC_WR_COLOR);
  assign color_addr = (itd.func == FUNC_RENDER) ? qi : itd.address[QW-1:0];

  ssc_ram #(.WIDTH(24), .DEPTH(TABLE_SIZE)) u_color_ram (
    .clk(clk), .we(color_we), .addr(color_addr),
    .wdata(itd.color_in), .rdata(color_rdata)
  );

  // Stage 7: color read.
  logic     v7;
  in_item_t it7;
  logic     crop7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else     v7 <= vdi;
  end
  always_ff @(posedge clk) begin
    it7   <= itd;
    crop7 <= sidei[IW];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v7 && (it7.func == FUNC_RENDER);
  end
  always_ff @(posedge clk) begin
    result.out_x       <= it7.pixel_x;
    result.out_y       <= it7.pixel_y;
    result.color_out   <= crop7 ? 24'd0 : color_rdata;
    result.was_cropped <= crop7;
  end

endmodule

`default_nettype wire

// ===== sv/ssc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssc_checker import ssc_pkg::*; #(
  parameter int TABLE_SIZE = 1024
) (
  input wire       clk,
  input wire       rst,
  input wire       start,
  input in_item_t  item,
  input wire       busy,
  input wire       done,
  input out_item_t result
);

  localparam int LAT = 25 + $clog2(TABLE_SIZE);

  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_render_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.func == FUNC_RENDER) |-> ##LAT done)
    else $error("render transfer produced no result");

  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && item.func == FUNC_RENDER, LAT))
    else $error("result without a render transfer");

  a_coords_echo: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.out_x == $past(item.pixel_x, LAT))
          && (result.out_y == $past(item.pixel_y, LAT)))
    else $error("result coordinates do not match the request");

  a_cropped_black: assert property (@(posedge clk) disable iff (rst)
    (done && result.was_cropped) |-> (result.color_out == 24'd0))
    else $error("cropped pixel is not black");

endmodule

bind scaled_slice_colormap_render_core ssc_checker #(.TABLE_SIZE(TABLE_SIZE)) u_ssc_checker (
  .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
  .done(done), .result(result)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ssc_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEM_BITS = $bits(in_item_t);

  logic        clk;
  logic        rst;
  logic        start;
  in_item_t    item;
  logic        busy;
  logic        done;
  out_item_t   result;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  scaled_slice_colormap_render_core u_top (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Shadow copy of the register file.
  logic [31:0]        slice_dims;
  logic [31:0]        plot_dims;
  logic signed [15:0] win_lo;
  logic signed [15:0] win_hi;
  logic [31:0]        crop_x;
  logic [31:0]        crop_y;
  logic [1:0]         view_bits;

  // Shadow memories, updated as items transfer.
  logic signed [15:0] slice_mem [65536];
  logic [23:0]        palette_mem [1024];
  // What the stimulus has already queued, so renders never hit unwritten data.
  bit                 word_loaded [65536];
  logic signed [15:0] queued_sample [65536];
  bit                 color_loaded [1024];

  in_item_t  pending_items [$];
  out_item_t expected_pixels [$];
  bit        failed;
  bit        took;
  int        burst_left;
  int        gap_left;
  int unsigned cycle_count;

  function automatic logic [15:0] source_word(input logic [15:0] px, input logic [15:0] py,
                                              output bit cropped);
    longint unsigned cols, rows, pw, ph, sx, sy;
    cols = (slice_dims[15:0] == 0) ? 1 : slice_dims[15:0];
    rows = (slice_dims[31:16] == 0) ? 1 : slice_dims[31:16];
    pw = (plot_dims[15:0] == 0) ? 1 : plot_dims[15:0];
    ph = (plot_dims[31:16] == 0) ? 1 : plot_dims[31:16];
    sx = (longint'(px) * cols) / pw;
    sy = (longint'(py) * rows) / ph;
    if (sx > cols - 1) sx = cols - 1;
    if (sy > rows - 1) sy = rows - 1;
    if (view_bits[0]) sy = rows - 1 - sy;
    cropped = view_bits[1] || sx < crop_x[15:0] || sx > crop_x[31:16]
              || sy < crop_y[15:0] || sy > crop_y[31:16];
    return 16'((sy * cols + sx) % 65536);
  endfunction

  // Color table index of a sample under the current value window.
  function automatic int color_index(input logic signed [15:0] s);
    int lo, hi, v, idx;
    lo = win_lo;
    hi = (win_hi > win_lo) ? int'(win_hi) : lo + 1;
    v = s;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    idx = ((v - lo) * 1023) / (hi - lo);
    if (idx < 0) idx = 0;
    if (idx > 1023) idx = 1023;
    return idx;
  endfunction

  function automatic out_item_t render_pixel(input in_item_t it);
    out_item_t px_out;
    bit cropped;
    logic [15:0] w;
    w = source_word(it.pixel_x, it.pixel_y, cropped);
    px_out.out_x = it.pixel_x;
    px_out.out_y = it.pixel_y;
    px_out.was_cropped = cropped;
    px_out.color_out = '0;
    if (!cropped) begin
      px_out.color_out = palette_mem[color_index(slice_mem[w])];
    end
    return px_out;
  endfunction

  // Input side: record the transfer and update the shadow state.
  always @(posedge clk) begin
    took = !rst && start && !busy;
    if (took) begin
      case (item.func)
        FUNC_WR_SAMPLE: slice_mem[item.address] = item.sample;
        FUNC_WR_COLOR:  palette_mem[item.address[9:0]] = item.color_in;
        FUNC_RENDER:    expected_pixels.push_back(render_pixel(item));
        default: ;
      endcase
    end
  end

  // Output side: results cannot be held off, so every strobe is checked.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result x=%0d y=%0d", result.out_x, result.out_y);
        failed = 1'b1;
      end else begin
        want = expected_pixels.pop_front();
        if (result.out_x !== want.out_x) begin
          $error("out_x expected %0d actual %0d", want.out_x, result.out_x);
          failed = 1'b1;
        end
        if (result.out_y !== want.out_y) begin
          $error("out_y expected %0d actual %0d", want.out_y, result.out_y);
          failed = 1'b1;
        end
        if (result.color_out !== want.color_out) begin
          $error("color_out expected %06h actual %06h", want.color_out, result.color_out);
          failed = 1'b1;
        end
        if (result.was_cropped !== want.was_cropped) begin
          $error("was_cropped expected %0b actual %0b", want.was_cropped, result.was_cropped);
          failed = 1'b1;
        end
      end
    end
  end

  // Sender works in bursts with random gaps; a held start stays up until its transfer.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (took) void'(pending_items.pop_front());
      if (start && !took) begin
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        start <= 1'b1;
        item <= pending_items[0];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
          gap_left = $urandom_range(0, 6);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL scaled_slice_colormap_render_core");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SLICE_SIZE:   slice_dims = data;
      REG_PLOT_SIZE:    plot_dims = data;
      REG_VALUE_MIN:    win_lo = data[15:0];
      REG_VALUE_MAX:    win_hi = data[15:0];
      REG_CROP_COLUMNS: crop_x = data;
      REG_CROP_ROWS:    crop_y = data;
      REG_VIEW_MODE:    view_bits = data[1:0];
      default: ;
    endcase
  endtask

  // Program all registers; upper data bits of the narrow ones carry noise.
  task automatic apply_setting(input logic [31:0] sz, input logic [31:0] pl,
                               input logic [15:0] lo, input logic [15:0] hi,
                               input logic [31:0] cx, input logic [31:0] cy,
                               input logic [1:0] vm);
    write_reg(REG_SLICE_SIZE, sz);
    write_reg(REG_PLOT_SIZE, pl);
    write_reg(REG_VALUE_MIN, {16'($urandom), lo});
    write_reg(REG_VALUE_MAX, {16'($urandom), hi});
    write_reg(REG_CROP_COLUMNS, cx);
    write_reg(REG_CROP_ROWS, cy);
    write_reg(REG_VIEW_MODE, {30'($urandom), vm});
  endtask

  function automatic in_item_t noise_item(input logic [1:0] f);
    in_item_t it;
    it = ITEM_BITS'({$urandom, $urandom, $urandom});
    it.func = f;
    return it;
  endfunction

  task automatic push_sample(input logic [15:0] addr, input logic [15:0] value);
    in_item_t it;
    it = noise_item(FUNC_WR_SAMPLE);
    it.address = addr;
    it.sample = value;
    word_loaded[addr] = 1'b1;
    queued_sample[addr] = value;
    pending_items.push_back(it);
  endtask

  // High address bits carry noise to exercise the wrap.
  task automatic push_color(input logic [9:0] idx);
    in_item_t it;
    it = noise_item(FUNC_WR_COLOR);
    it.address[9:0] = idx;
    color_loaded[idx] = 1'b1;
    pending_items.push_back(it);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(win_lo + $urandom_range(0, 3));
      3: return 16'(win_hi - $urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // A render whose source word or color entry was never loaded gets a load queued ahead.
  task automatic push_render(input logic [15:0] px, input logic [15:0] py);
    in_item_t it;
    bit cropped;
    logic [15:0] w;
    int idx;
    w = source_word(px, py, cropped);
    if (!cropped) begin
      if (!word_loaded[w]) push_sample(w, pick_sample());
      idx = color_index(queued_sample[w]);
      if (!color_loaded[idx]) push_color(10'(idx));
    end
    it = noise_item(FUNC_RENDER);
    it.pixel_x = px;
    it.pixel_y = py;
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_traffic(input int count);
    in_item_t it;
    int pw, ph, cols;
    pw = (plot_dims[15:0] == 0) ? 1 : plot_dims[15:0];
    ph = (plot_dims[31:16] == 0) ? 1 : plot_dims[31:16];
    cols = (slice_dims[15:0] == 0) ? 1 : slice_dims[15:0];
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:
          push_sample(($urandom_range(0, 1) == 0) ? 16'($urandom)
                      : 16'($urandom_range(0, 63) * cols + $urandom_range(0, cols)),
                      pick_sample());
        6, 7: begin
          it = noise_item(FUNC_WR_COLOR);
          color_loaded[it.address[9:0]] = 1'b1;
          pending_items.push_back(it);
        end
        8: pending_items.push_back(noise_item(FUNC_UNUSED));
        9, 10: push_render(16'($urandom), 16'($urandom));
        default: push_render(16'($urandom_range(0, pw)), 16'($urandom_range(0, ph)));
      endcase
    end
    wait_idle();
  endtask

  initial begin
    int cols, rows, c0, r0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    failed = 1'b0;
    took = 1'b0;
    burst_left = 0;
    gap_left = 0;
    cycle_count = 0;
    slice_dims = 32'h0001_0001;
    plot_dims = 32'h0001_0001;
    win_lo = 16'sh8000;
    win_hi = 16'sh7fff;
    crop_x = 32'hffff_0000;
    crop_y = 32'hffff_0000;
    view_bits = 2'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: a one-word slice, full-scale extremes, pixels beyond the plot.
    push_sample(16'd0, 16'h8000);
    push_render(16'd0, 16'd0);
    push_render(16'hffff, 16'hffff);
    push_sample(16'd0, 16'h7fff);
    push_render(16'd0, 16'd0);
    push_sample(16'd0, 16'h0000);
    push_render(16'd1, 16'hffff);
    push_sample(16'hffff, 16'h1234);
    pending_items.push_back(noise_item(FUNC_UNUSED));
    push_render(16'h8000, 16'd0);
    wait_idle();

    apply_setting(32'h0010_0010, 32'h0020_0020, 16'shff9c, 16'sh0064,
                  32'hffff_0000, 32'hffff_0000, 2'd0);
    random_traffic(60);
    // Zero dimensions and an empty value window with row flip.
    apply_setting(32'h0000_0000, 32'h0000_0000, 16'sh0005, 16'sh0005,
                  32'hffff_0000, 32'hffff_0000, 2'd1);
    random_traffic(40);
    apply_setting(32'hffff_ffff, 32'hffff_ffff, 16'sh7fff, 16'sh8000,
                  32'h00f0_0010, 32'hffff_0000, 2'd3);
    random_traffic(40);
    apply_setting(32'h0040_0100, 32'h0020_0040, 16'sh8000, 16'sh7fff,
                  32'h00c0_0020, 32'h0030_0008, 2'd1);
    random_traffic(60);
    apply_setting(32'h0008_0020, 32'h0100_0100, 16'sh0000, 16'sh0400,
                  32'hffff_0000, 32'hffff_0000, 2'd2);
    random_traffic(30);
    apply_setting(32'hffff_ffff, 32'h0040_0040, 16'sh8000, 16'sh8001,
                  32'hffff_0000, 32'hffff_0000, 2'd1);
    random_traffic(50);

    for (int ph_i = 0; ph_i < 6; ph_i++) begin
      cols = $urandom_range(1, 300);
      rows = $urandom_range(1, 300);
      c0 = $urandom_range(0, cols / 2);
      r0 = $urandom_range(0, rows / 2);
      apply_setting({16'(rows), 16'(cols)},
                    {16'($urandom_range(1, 400)), 16'($urandom_range(1, 400))},
                    16'($urandom), 16'($urandom),
                    ($urandom_range(0, 3) == 0) ? 32'hffff_0000
                      : {16'($urandom_range(c0, cols + 4)), 16'(c0)},
                    ($urandom_range(0, 3) == 0) ? 32'hffff_0000
                      : {16'($urandom_range(r0, rows + 4)), 16'(r0)},
                    ($urandom_range(0, 4) == 0) ? 2'($urandom) : 2'($urandom_range(0, 1)));
      random_traffic(50);
    end

    if (!failed && expected_pixels.size() == 0) begin
      $display("PASS scaled_slice_colormap_render_core");
    end else begin
      $display("FAIL scaled_slice_colormap_render_core");
    end
    $finish;
  end

endmodule

// ===== scaled_slice_colormap_render_core.f =====
sv/ssc_pkg.sv
sv/ssc_ram.sv
sv/ssc_div.sv
sv/scaled_slice_colormap_render_core.sv
sv/ssc_checker.sv
tb/sv/tb.sv
